@@ rtl/mmcr_pkg.sv @@
// ----------------------------------------------------------------------------
// mmcr_pkg
// Shared types and constants of the card command responder: command codes,
// data operation codes, register indexes, response constants and the structs
// that pass between the responder modules.
// ----------------------------------------------------------------------------
package mmcr_pkg;

   // Field widths
   localparam int CMD_W      = 6;
   localparam int WORD_W     = 32;
   localparam int RCA_W      = 16;
   localparam int SSIZE_W    = 16;
   localparam int SHIFT_W    = 4;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_GO_IDLE        = 6'd0;
   localparam logic [CMD_W-1:0] CMD_ALL_SEND_CID   = 6'd2;
   localparam logic [CMD_W-1:0] CMD_SET_RCA        = 6'd3;
   localparam logic [CMD_W-1:0] CMD_SET_DSR        = 6'd4;
   localparam logic [CMD_W-1:0] CMD_SWITCH         = 6'd6;
   localparam logic [CMD_W-1:0] CMD_SELECT         = 6'd7;
   localparam logic [CMD_W-1:0] CMD_SEND_CSD       = 6'd9;
   localparam logic [CMD_W-1:0] CMD_SEND_CID       = 6'd10;
   localparam logic [CMD_W-1:0] CMD_READ_DAT_UNTIL = 6'd11;
   localparam logic [CMD_W-1:0] CMD_STOP_TRANS     = 6'd12;
   localparam logic [CMD_W-1:0] CMD_SEND_STATUS    = 6'd13;
   localparam logic [CMD_W-1:0] CMD_BUS_TEST_R     = 6'd14;
   localparam logic [CMD_W-1:0] CMD_SET_BLOCKLEN   = 6'd16;
   localparam logic [CMD_W-1:0] CMD_READ_SINGLE    = 6'd17;
   localparam logic [CMD_W-1:0] CMD_READ_MULTIPLE  = 6'd18;
   localparam logic [CMD_W-1:0] CMD_WRITE_DAT_UNTIL = 6'd20;
   localparam logic [CMD_W-1:0] CMD_SET_BLOCK_CNT  = 6'd23;
   localparam logic [CMD_W-1:0] CMD_WRITE_SINGLE   = 6'd24;
   localparam logic [CMD_W-1:0] CMD_WRITE_MULTIPLE = 6'd25;
   localparam logic [CMD_W-1:0] CMD_SET_WP         = 6'd28;
   localparam logic [CMD_W-1:0] CMD_CLR_WP         = 6'd29;
   localparam logic [CMD_W-1:0] CMD_SEND_WP        = 6'd30;
   localparam logic [CMD_W-1:0] CMD_ERASE_START    = 6'd35;
   localparam logic [CMD_W-1:0] CMD_ERASE_END      = 6'd36;
   localparam logic [CMD_W-1:0] CMD_ERASE_GROUP    = 6'd37;
   localparam logic [CMD_W-1:0] CMD_SD_SEND_OP     = 6'd41;
   localparam logic [CMD_W-1:0] CMD_LOCK_UNLOCK    = 6'd42;
   localparam logic [CMD_W-1:0] CMD_APP_CMD        = 6'd55;
   localparam logic [CMD_W-1:0] CMD_GEN_CMD        = 6'd56;

   // Data operation codes
   localparam logic [OP_W-1:0] OP_NONE          = 2'd0;
   localparam logic [OP_W-1:0] OP_READ_SINGLE   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_MULTIPLE = 2'd2;
   localparam logic [OP_W-1:0] OP_WRITE_SINGLE  = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_SIZE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE_LOG2 = 2'd2;

   // Reset values
   localparam logic [SSIZE_W-1:0] SECTOR_SIZE_RST     = 16'd512;
   localparam logic [WORD_W-1:0]  SECTOR_COUNT_RST    = 32'd0;
   localparam logic [SHIFT_W-1:0] BLOCK_SIZE_LOG2_RST = 4'd9;
   localparam logic [RCA_W-1:0]   RCA_RST             = 16'h0010;

   // Response constants
   localparam logic [WORD_W-1:0] BLOCK_LEN_OK    = 32'd512;
   localparam logic [WORD_W-1:0] SELECT_STATUS   = 32'h0000_0800;
   localparam logic [WORD_W-1:0] CARD_STATUS     = 32'h0000_0100;
   localparam logic [WORD_W-1:0] OCR_DEFAULT     = 32'h80FF_8000;
   localparam logic [WORD_W-1:0] OCR_BUSY_DONE   = 32'h8000_0000;
   localparam logic [WORD_W-1:0] CSD_WORD0       = 32'h1209_0132;
   localparam logic [WORD_W-1:0] CSD_WORD1_BASE  = 32'h0FF9_1000;
   localparam logic [WORD_W-3:0] CSD_WORD2_LOW   = 30'h0926_D001;
   localparam logic [WORD_W-1:0] CSD_WORD3       = 32'h8240_0001;
   localparam logic [WORD_W-1:0] CID_WORD0       = 32'hABCD_EF61;
   localparam logic [WORD_W-1:0] CID_WORD1       = 32'h6E74_6973;
   localparam logic [WORD_W-1:0] CID_WORD2       = 32'h5A78_5634;
   localparam logic [WORD_W-1:0] CID_WORD3       = 32'h1200_4A01;

   // Configuration seen by the response logic
   typedef struct packed {
      logic [SSIZE_W-1:0] sector_size;
      logic [WORD_W-1:0]  sector_count;
      logic [SHIFT_W-1:0] block_size_log2;
   } cfg_type;

   // Card identification state
   typedef struct packed {
      logic             identified;
      logic [RCA_W-1:0] rca;
   } card_state_type;

   // One response
   typedef struct packed {
      logic [WORD_W-1:0] resp_word0;
      logic [WORD_W-1:0] resp_word1;
      logic [WORD_W-1:0] resp_word2;
      logic [WORD_W-1:0] resp_word3;
      logic              timed_out;
      logic [OP_W-1:0]   data_op;
      logic [WORD_W-1:0] block_address;
   } rsp_type;

endpackage

@@ rtl/mmcr_if.sv @@
// ----------------------------------------------------------------------------
// mmcr interfaces
// Valid/ready channels of the responder: command requests, responses and
// configuration register writes.
// ----------------------------------------------------------------------------
interface mmcr_req_if import mmcr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command_index;
   logic [WORD_W-1:0] argument;

   modport source (output valid, output command_index, output argument, input ready);
   modport sink   (input valid, input command_index, input argument, output ready);
endinterface

interface mmcr_rsp_if import mmcr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] resp_word0;
   logic [WORD_W-1:0] resp_word1;
   logic [WORD_W-1:0] resp_word2;
   logic [WORD_W-1:0] resp_word3;
   logic              timed_out;
   logic [OP_W-1:0]   data_op;
   logic [WORD_W-1:0] block_address;

   modport source (output valid, output resp_word0, output resp_word1, output resp_word2,
                   output resp_word3, output timed_out, output data_op,
                   output block_address, input ready);
   modport sink   (input valid, input resp_word0, input resp_word1, input resp_word2,
                   input resp_word3, input timed_out, input data_op,
                   input block_address, output ready);
endinterface

interface mmcr_csr_if import mmcr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mmc_card_command_responder_unit.sv @@
// ----------------------------------------------------------------------------
// mmc_card_command_responder_unit
// Card-side SD/MMC command responder: one response per command request.
// ----------------------------------------------------------------------------
// Takes one command request per clock while responses are taken and returns
// one response per request, in order. A request is registered on acceptance
// in the input register, decoded in the next cycle (address checks, CSD
// capacity multiply, identification state update) in the single decode stage
// and its response held in an output register. When the response is not
// taken, the output register stalls, and the input register stalls as well
// while it holds a request. Configuration writes are taken every cycle and
// apply to requests decoded afterwards.
module mmc_card_command_responder_unit import mmcr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mmcr_req_if.sink  req_bus,
   mmcr_rsp_if.source rsp_bus,
   mmcr_csr_if.sink  csr_bus
);

   cfg_type           cfg;
   card_state_type    card_ff;
   card_state_type    card_in;
   card_state_type    card_nxt;
   rsp_type           rsp_calc;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic              req_valid_ff;
   logic [CMD_W-1:0]  cmd_ff;
   logic [WORD_W-1:0] arg_ff;
   logic              out_load;
   logic              in_load;

   mmcr_csr_regs u_csr_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   mmcr_resp_logic u_resp_logic (
      .command_index (cmd_ff),
      .argument      (arg_ff),
      .cfg           (cfg),
      .card_cur      (card_ff),
      .card_nxt      (card_nxt),
      .rsp           (rsp_calc)
   );

   // Advance when the next stage has room
   assign out_load      = !rsp_valid_ff || rsp_bus.ready;
   assign in_load       = !req_valid_ff || out_load;
   assign req_bus.ready = in_load;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (in_load) begin
         req_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_bus.valid) begin
         cmd_ff <= req_bus.command_index;
         arg_ff <= req_bus.argument;
      end
   end

   // Update card state as a request moves to the output
   always_comb begin
      card_in = card_ff;
      if (req_valid_ff && out_load) card_in = card_nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         card_ff.identified <= 1'b0;
         card_ff.rca        <= RCA_RST;
      end else begin
         card_ff <= card_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && req_valid_ff) begin
         rsp_ff <= rsp_calc;
      end
   end

   // Drive the response channel
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.resp_word0    = rsp_ff.resp_word0;
   assign rsp_bus.resp_word1    = rsp_ff.resp_word1;
   assign rsp_bus.resp_word2    = rsp_ff.resp_word2;
   assign rsp_bus.resp_word3    = rsp_ff.resp_word3;
   assign rsp_bus.timed_out     = rsp_ff.timed_out;
   assign rsp_bus.data_op       = rsp_ff.data_op;
   assign rsp_bus.block_address = rsp_ff.block_address;

endmodule

@@ rtl/mmcr_csr_regs.sv @@
// ----------------------------------------------------------------------------
// mmcr_csr_regs
// Configuration registers: sector size, sector count and block size shift,
// written through the register write channel.
// ----------------------------------------------------------------------------
module mmcr_csr_regs import mmcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   mmcr_csr_if.sink      csr_bus,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always take writes
   assign csr_bus.ready = 1'b1;

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_SECTOR_SIZE:     cfg_in.sector_size     = csr_bus.data[SSIZE_W-1:0];
            CSR_SECTOR_COUNT:    cfg_in.sector_count    = csr_bus.data;
            CSR_BLOCK_SIZE_LOG2: cfg_in.block_size_log2 = csr_bus.data[SHIFT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sector_size     <= SECTOR_SIZE_RST;
         cfg_ff.sector_count    <= SECTOR_COUNT_RST;
         cfg_ff.block_size_log2 <= BLOCK_SIZE_LOG2_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/mmcr_resp_logic.sv @@
// ----------------------------------------------------------------------------
// mmcr_resp_logic
// Command decoder: builds the response words, timeout flag, data operation
// and block address of one command, and the card state it leaves behind.
// ----------------------------------------------------------------------------
module mmcr_resp_logic import mmcr_pkg::*; (
   input  logic [CMD_W-1:0]  command_index,
   input  logic [WORD_W-1:0] argument,
   input  cfg_type           cfg,
   input  card_state_type    card_cur,
   output card_state_type    card_nxt,
   output rsp_type           rsp
);

   logic [WORD_W-1:0] addr_arg;
   logic              addr_match;
   logic              arg_zero;
   logic [WORD_W-1:0] capacity;
   logic [RCA_W-1:0]  blks;
   logic [WORD_W-1:0] shifted_arg;
   logic              send_cid;

   // Address compare and capacity
   assign addr_arg    = {card_cur.rca, {RCA_W{1'b0}}};
   assign addr_match  = (argument == addr_arg);
   assign arg_zero    = (argument == '0);
   assign capacity    = {{(WORD_W-SSIZE_W){1'b0}}, cfg.sector_size} * cfg.sector_count;
   assign blks        = capacity[WORD_W-1:WORD_W-RCA_W];
   assign shifted_arg = argument >> cfg.block_size_log2;

   // Decode the command
   always_comb begin
      rsp      = '0;
      card_nxt = card_cur;
      send_cid = 1'b0;
      case (command_index)
         CMD_READ_SINGLE: begin
            rsp.data_op       = OP_READ_SINGLE;
            rsp.block_address = shifted_arg;
         end
         CMD_READ_MULTIPLE: begin
            rsp.data_op       = OP_READ_MULTIPLE;
            rsp.block_address = shifted_arg;
         end
         CMD_WRITE_SINGLE: begin
            rsp.data_op       = OP_WRITE_SINGLE;
            rsp.block_address = shifted_arg;
         end
         CMD_GO_IDLE: begin
            card_nxt.identified = 1'b0;
         end
         CMD_ALL_SEND_CID: begin
            if (card_cur.identified) rsp.timed_out = 1'b1;
            else                     send_cid      = 1'b1;
         end
         CMD_SET_RCA: begin
            card_nxt.rca        = argument[WORD_W-1:WORD_W-RCA_W];
            card_nxt.identified = 1'b1;
            rsp.resp_word0      = {argument[WORD_W-1:WORD_W-RCA_W], {RCA_W{1'b0}}};
         end
         CMD_SELECT: begin
            if (!arg_zero) begin
               if (addr_match) rsp.resp_word0 = SELECT_STATUS;
               else            rsp.timed_out  = 1'b1;
            end
         end
         CMD_SEND_CSD: begin
            if (addr_match) begin
               rsp.resp_word0 = CSD_WORD0;
               rsp.resp_word1 = CSD_WORD1_BASE | {18'd0, blks[RCA_W-1:2]};
               rsp.resp_word2 = {blks[1:0], CSD_WORD2_LOW};
               rsp.resp_word3 = CSD_WORD3;
            end else begin
               rsp.timed_out = 1'b1;
            end
         end
         CMD_SEND_CID: begin
            if (addr_match) send_cid      = 1'b1;
            else            rsp.timed_out = 1'b1;
         end
         CMD_SEND_STATUS: begin
            if (addr_match) rsp.resp_word0 = CARD_STATUS;
            else            rsp.timed_out  = 1'b1;
         end
         CMD_SET_BLOCKLEN: begin
            if (argument != BLOCK_LEN_OK) rsp.timed_out = 1'b1;
         end
         CMD_APP_CMD: begin
            if (addr_match || arg_zero) rsp.resp_word0 = argument;
            else                        rsp.timed_out  = 1'b1;
         end
         CMD_SD_SEND_OP: begin
            rsp.resp_word0 = arg_zero ? OCR_DEFAULT : (argument | OCR_BUSY_DONE);
         end
         CMD_SET_DSR, CMD_SWITCH, CMD_READ_DAT_UNTIL, CMD_STOP_TRANS, CMD_BUS_TEST_R,
         CMD_WRITE_DAT_UNTIL, CMD_SET_BLOCK_CNT, CMD_WRITE_MULTIPLE, CMD_SET_WP,
         CMD_CLR_WP, CMD_SEND_WP, CMD_ERASE_START, CMD_ERASE_END, CMD_ERASE_GROUP,
         CMD_LOCK_UNLOCK, CMD_GEN_CMD: begin
            rsp.timed_out = 1'b0;
         end
         default: begin
            rsp.timed_out = 1'b1;
         end
      endcase

      // Overlay the card identification words
      if (send_cid) begin
         rsp.resp_word0 = CID_WORD0;
         rsp.resp_word1 = CID_WORD1;
         rsp.resp_word2 = CID_WORD2;
         rsp.resp_word3 = CID_WORD3;
      end
   end

endmodule
